// ===== rtl/fzsd_pkg.sv =====
// fzsd_pkg: shared widths, codes and types for the four zone swipe detector
// no dependencies; used by fzsd_cell, fzsd_zone and four_zone_swipe_detector

package fzsd_pkg;

  localparam int NZONES   = 4;
  localparam int SAMPLE_W = 12;
  localparam int THR_W    = 12;
  localparam int LIMIT_W  = 16;
  localparam int CNT_W    = LIMIT_W + 1;
  localparam int CFG_W    = 16;
  localparam int ADDR_W   = 1;
  localparam int CODE_W   = 3;
  localparam int TREND_W  = 2;
  localparam int IN_W     = NZONES * SAMPLE_W;
  localparam int OUT_W    = 16;

  // value every window entry takes after an accepted swipe
  localparam logic [SAMPLE_W-1:0] REFILL_VALUE = SAMPLE_W'(135);

  // configuration register indexes
  localparam logic [ADDR_W-1:0] CFG_CHANGE_THRESHOLD = 1'b0;
  localparam logic [ADDR_W-1:0] CFG_HOLDOFF_LIMIT    = 1'b1;

  // zone trend codes, two bit signed
  localparam logic [TREND_W-1:0] TREND_STILL = 2'b00;
  localparam logic [TREND_W-1:0] TREND_UP    = 2'b01;
  localparam logic [TREND_W-1:0] TREND_DOWN  = 2'b11;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [NZONES-1:0] zone_vec_t;
  typedef logic [TREND_W-1:0] trend_t;

  typedef enum logic [CODE_W-1:0] {
    SWIPE_NONE   = 3'd0,
    SWIPE_POS_X  = 3'd1,
    SWIPE_NEG_X  = 3'd2,
    SWIPE_POS_Y  = 3'd3,
    SWIPE_NEG_Y  = 3'd4
  } swipe_t;

  // control from the hold-off logic to the window cells and zone sums
  typedef struct packed {
    logic shift;
    logic refill;
  } win_ctl_t;

endpackage

// ===== rtl/fzsd_cell.sv =====
// fzsd_cell: one slot of the sample window, holding a sample of each zone
// depends on fzsd_pkg

module fzsd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  fzsd_pkg::win_ctl_t  ctl,
  input  fzsd_pkg::zone_vec_t d_in,
  output fzsd_pkg::zone_vec_t q
);

  fzsd_pkg::zone_vec_t q_r;
  fzsd_pkg::zone_vec_t q_nxt;

  // refill overrides the shift of the same word
  always_comb begin
    q_nxt = q_r;
    if (ctl.refill) begin
      for (int z = 0; z < fzsd_pkg::NZONES; z++) q_nxt[z] = fzsd_pkg::REFILL_VALUE;
    end else if (ctl.shift) begin
      q_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/fzsd_zone.sv =====
// fzsd_zone: running window sum of one zone and its rise/fall test
// depends on fzsd_pkg

module fzsd_zone #(
  parameter int WINDOW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fzsd_pkg::win_ctl_t          ctl,
  input  fzsd_pkg::sample_t           sample,
  input  fzsd_pkg::sample_t           oldest,
  input  logic [fzsd_pkg::THR_W-1:0]  thr,
  output fzsd_pkg::trend_t            trend
);

  localparam int SUM_W = fzsd_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int CMP_W = SUM_W + 1;
  localparam logic [SUM_W-1:0] REFILL_SUM = SUM_W'(135 * WINDOW);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0] sum_new;
  logic [CMP_W-1:0] scaled;
  logic [CMP_W-1:0] margin;

  // sum after this word replaces the oldest one
  assign sum_new = sum_r - SUM_W'(oldest) + SUM_W'(sample);

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.refill) begin
      sum_nxt = REFILL_SUM;
    end else if (ctl.shift) begin
      sum_nxt = sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  // mean test scaled by the window length
  assign scaled = CMP_W'(sample) * CMP_W'(WINDOW);
  assign margin = CMP_W'(thr) * CMP_W'(WINDOW);

  always_comb begin
    if (scaled > CMP_W'(sum_new) + margin) begin
      trend = fzsd_pkg::TREND_UP;
    end else if (scaled + margin < CMP_W'(sum_new)) begin
      trend = fzsd_pkg::TREND_DOWN;
    end else begin
      trend = fzsd_pkg::TREND_STILL;
    end
  end

endmodule

// ===== rtl/four_zone_swipe_detector.sv =====
// four_zone_swipe_detector: top level, window cell chain, zone sums, hold-off
// depends on fzsd_pkg, fzsd_cell and fzsd_zone

// Takes one word of four zone samples per clock and returns one result word per
// input word, in the next cycle from an output register; a new word is taken
// every cycle while the result side accepts. The window is a chain of WINDOW
// cells that shift on every accepted word, the oldest leaving at the far end,
// and each zone keeps a running sum (one add, one subtract per word) for the
// two-way mean test; that path sets the clock. An accepted swipe reloads every
// cell and sum in the same cycle, so no refill stall exists. The user must write
// configuration via cfg_we/cfg_addr/cfg_wdata while idle; nothing enforces it.

module four_zone_swipe_detector #(
  parameter int WINDOW = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [fzsd_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [fzsd_pkg::CFG_W-1:0]      cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sample_0, sample_1, sample_2, sample_3 (12 bits each)
  input  logic [fzsd_pkg::IN_W-1:0]       in_tdata,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // swipe_code (3), holdoff_active (1), trend_0..trend_3 (2 each), zero pad (4)
  output logic [fzsd_pkg::OUT_W-1:0]      out_tdata
);

  localparam int SW = fzsd_pkg::SAMPLE_W;
  localparam int CW = fzsd_pkg::CNT_W;

  logic [fzsd_pkg::THR_W-1:0]   thr_r;
  logic [fzsd_pkg::LIMIT_W-1:0] limit_r;
  logic                         sup_r, sup_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [fzsd_pkg::OUT_W-1:0]   out_data_r;

  logic                  accept;
  fzsd_pkg::zone_vec_t   samples;
  fzsd_pkg::zone_vec_t   win_q [WINDOW];
  fzsd_pkg::trend_t      trend [fzsd_pkg::NZONES];
  fzsd_pkg::win_ctl_t    ctl;
  fzsd_pkg::swipe_t      dec, code;
  logic [CW-1:0]         cnt_inc, cnt_a;
  logic                  expire, sup_a, take;

  function automatic fzsd_pkg::swipe_t decode_swipe(
    input fzsd_pkg::trend_t t0, input fzsd_pkg::trend_t t1,
    input fzsd_pkg::trend_t t2, input fzsd_pkg::trend_t t3);
    logic u0, u1, u2, u3, d0, d1, d2, d3;
    fzsd_pkg::swipe_t s;
    u0 = (t0 == fzsd_pkg::TREND_UP);
    u1 = (t1 == fzsd_pkg::TREND_UP);
    u2 = (t2 == fzsd_pkg::TREND_UP);
    u3 = (t3 == fzsd_pkg::TREND_UP);
    d0 = (t0 == fzsd_pkg::TREND_DOWN);
    d1 = (t1 == fzsd_pkg::TREND_DOWN);
    d2 = (t2 == fzsd_pkg::TREND_DOWN);
    d3 = (t3 == fzsd_pkg::TREND_DOWN);
    if (u0 && u1 && d2 && d3)      s = fzsd_pkg::SWIPE_POS_X;
    else if (d0 && d1 && u2 && u3) s = fzsd_pkg::SWIPE_NEG_X;
    else if (u0 && u3 && d1 && d2) s = fzsd_pkg::SWIPE_POS_Y;
    else if (d0 && d3 && u1 && u2) s = fzsd_pkg::SWIPE_NEG_Y;
    else                           s = fzsd_pkg::SWIPE_NONE;
    return s;
  endfunction

  // handshake: output register frees up when taken
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    for (int z = 0; z < fzsd_pkg::NZONES; z++) samples[z] = in_tdata[z*SW +: SW];
  end

  // window cell chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      fzsd_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl), .d_in(samples), .q(win_q[i]));
    end else begin : g_body
      fzsd_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl), .d_in(win_q[i-1]),
                        .q(win_q[i]));
    end
  end

  // running sums and trend tests
  for (genvar z = 0; z < fzsd_pkg::NZONES; z++) begin : g_zone
    fzsd_zone #(.WINDOW(WINDOW)) u_zone (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sample(samples[z]),
      .oldest(win_q[WINDOW-1][z]),
      .thr   (thr_r),
      .trend (trend[z])
    );
  end

  // hold-off sequencing and swipe acceptance
  always_comb begin
    dec     = decode_swipe(trend[0], trend[1], trend[2], trend[3]);
    code    = sup_r ? fzsd_pkg::SWIPE_NONE : dec;
    cnt_inc = sup_r ? cnt_r + CW'(1) : cnt_r;
    expire  = cnt_inc > CW'(limit_r);
    cnt_a   = expire ? '0 : cnt_inc;
    sup_a   = expire ? 1'b0 : sup_r;
    take    = (code != fzsd_pkg::SWIPE_NONE) && (cnt_a == '0);
    if (!take) code = fzsd_pkg::SWIPE_NONE;
    ctl.shift  = accept;
    ctl.refill = accept && take;
    sup_nxt = sup_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      sup_nxt = take ? 1'b1 : sup_a;
      cnt_nxt = cnt_a;
    end
    out_valid_nxt = accept ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sup_r       <= sup_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {4'b0000, trend[3], trend[2], trend[1], trend[0], sup_nxt, code};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= fzsd_pkg::THR_W'(10);
      limit_r <= fzsd_pkg::LIMIT_W'(200);
    end else if (cfg_we) begin
      case (cfg_addr)
        fzsd_pkg::CFG_CHANGE_THRESHOLD: thr_r   <= cfg_wdata[fzsd_pkg::THR_W-1:0];
        fzsd_pkg::CFG_HOLDOFF_LIMIT:    limit_r <= cfg_wdata[fzsd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // hold-off counter only runs while suppressed
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !sup_r |-> cnt_r == '0) else $error("hold-off count nonzero while armed");

  // stored count never reaches the top bit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[CW-1] == 1'b0) else $error("hold-off count out of range");

  // an accepted swipe starts suppression
  a_swipe_sup: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.refill |=> sup_r) else $error("swipe did not start hold-off");

  // a reported swipe always carries the hold-off flag
  a_out_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r[2:0] != fzsd_pkg::SWIPE_NONE) |-> out_data_r[3])
    else $error("swipe reported without hold-off");

endmodule
